// ===== rtl/dgsp_pkg.sv =====
// Shared types, constants and the poll command table for the dual gamepad poller.
// Has no dependencies; every other file in rtl/ imports it.
`timescale 1ns / 1ps
`default_nettype none

package dgsp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_CLOCK_LOW  = 2'd0;
  localparam logic [1:0] REG_CLOCK_HIGH = 2'd1;
  localparam logic [1:0] REG_BYTE_GAP   = 2'd2;

  localparam logic [7:0] RST_CLOCK_LOW  = 8'd4;
  localparam logic [7:0] RST_CLOCK_HIGH = 8'd0;
  localparam logic [7:0] RST_BYTE_GAP   = 8'd3;

  // Bytes of each pad that are kept, and the width of an index into them.
  localparam int unsigned STORED_BYTES = 5;
  localparam int unsigned RX_W         = 3;

  localparam logic [7:0] HDR_BYTE0 = 8'hFF;
  localparam logic [7:0] HDR_BYTE1 = 8'h41;
  localparam logic [7:0] HDR_BYTE2 = 8'h5A;

  localparam logic [7:0] CMD_BYTE0 = 8'h01;
  localparam logic [7:0] CMD_BYTE1 = 8'h42;
  localparam logic [7:0] CMD_BYTE2 = 8'h00;
  localparam logic [7:0] CMD_FILL  = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_LOW,
    PH_HIGH,
    PH_GAP
  } phase_t;

  // One result item; the last member sits in the lowest bits.
  typedef struct packed {
    logic        any_change;
    logic [31:0] released_mask;
    logic [31:0] pressed_mask;
    logic [31:0] held_mask;
    logic        pad_two_valid;
    logic        pad_one_valid;
    logic        done_res;
    logic        busy_res;
    logic        attention_pin;
    logic        command_pin;
    logic        clock_pin;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  // Command byte sent at a given frame position; bytes past the table are all ones.
  function automatic logic [7:0] command_byte(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:    val = CMD_BYTE0;
      5'd1:    val = CMD_BYTE1;
      5'd2:    val = CMD_BYTE2;
      default: val = CMD_FILL;
    endcase
    return val;
  endfunction

  function automatic logic header_ok(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2);
    return (b0 == HDR_BYTE0) && (b1 == HDR_BYTE1) && (b2 == HDR_BYTE2);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dual_gamepad_serial_poller.sv =====
// Top level of the dual gamepad serial poller: tick stream in, pin and button results out.
// Instantiates dgsp_seq and dgsp_outq; uses dgsp_pkg.
//
//   Channel  Direction  Payload
//   in_      slave      tuser: op; tdata: data_pad_one, data_pad_two
//   out_     master     tdata: pins, status, header flags, button masks
//   cfg_     write      index 0 clock low, 1 clock high, 2 byte gap
//
// One tick request is accepted every cycle while the queue has space; its result is
// registered in the queue before it leaves. The sequencer update for a tick is
// combinational; a two-entry result queue lets in_tready stay high until both
// entries are held by a stalled output. Reset is synchronous and active low;
// no clearing pass follows it. Configuration writes take effect on the next accepted tick.
`timescale 1ns / 1ps
`default_nettype none

module dual_gamepad_serial_poller
  import dgsp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 5
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [0] data_pad_one, [1] data_pad_two, rest zero
  input  wire logic         in_tuser,   // [0] op
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // [0] clock_pin, [1] command_pin, [2] attention_pin,
                                        // [3] busy_res, [4] done_res, [5] pad_one_valid,
                                        // [6] pad_two_valid, [38:7] held_mask,
                                        // [70:39] pressed_mask, [102:71] released_mask,
                                        // [103] any_change
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [7:0]   cfg_wdata
);

  logic    step;
  result_t tick_res;
  result_t q_data;

  assign step = in_tvalid && in_tready;

  dgsp_seq #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .step     (step),
    .op       (in_tuser),
    .data_one (in_tdata[0]),
    .data_two (in_tdata[1]),
    .res      (tick_res)
  );

  dgsp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (step),
    .push_data(tick_res),
    .space    (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (q_data)
  );

  assign out_tdata = 104'(q_data);

endmodule

`default_nettype wire

// ===== rtl/dgsp_seq.sv =====
// Frame sequencer: configuration registers, bit and byte timing, receive shifters
// and the button word evaluation. Uses dgsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dgsp_seq
  import dgsp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 5
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       step,
  input  wire logic       op,
  input  wire logic       data_one,
  input  wire logic       data_two,
  output result_t         res
);

  localparam int unsigned BI_W = $clog2(FRAME_BYTES);

  logic [7:0]      clock_low_r, clock_high_r, byte_gap_r;

  phase_t          phase_r, phase_nxt;
  logic [BI_W-1:0] byte_index_r, byte_index_nxt;
  logic [2:0]      bit_index_r, bit_index_nxt;
  logic [7:0]      tick_timer_r, tick_timer_nxt;
  logic [7:0]      shift_one_r, shift_one_nxt;
  logic [7:0]      shift_two_r, shift_two_nxt;
  logic [31:0]     button_r, button_nxt;
  logic [31:0]     prev_button_r, prev_button_nxt;
  logic [1:0]      valid_r, valid_nxt;
  logic            done_nxt;

  logic [7:0]      rx_one_r [STORED_BYTES];
  logic [7:0]      rx_two_r [STORED_BYTES];
  logic            rx_we;
  logic [RX_W-1:0] rx_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_low_r  <= RST_CLOCK_LOW;
      clock_high_r <= RST_CLOCK_HIGH;
      byte_gap_r   <= RST_BYTE_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLOCK_LOW:  clock_low_r  <= cfg_wdata;
        REG_CLOCK_HIGH: clock_high_r <= cfg_wdata;
        REG_BYTE_GAP:   byte_gap_r   <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Next state for one tick.
  always_comb begin
    logic [8:0]      tick_inc;
    logic [8:0]      low_len;
    logic [BI_W:0]   bi_inc;
    logic            byte_end;
    tick_inc = {1'b0, tick_timer_r} + 9'd1;
    low_len  = (clock_low_r == 8'd0) ? 9'd1 : {1'b0, clock_low_r};
    bi_inc   = {1'b0, byte_index_r} + {{BI_W{1'b0}}, 1'b1};
    byte_end = 1'b0;

    phase_nxt       = phase_r;
    byte_index_nxt  = byte_index_r;
    bit_index_nxt   = bit_index_r;
    tick_timer_nxt  = tick_timer_r;
    shift_one_nxt   = shift_one_r;
    shift_two_nxt   = shift_two_r;
    button_nxt      = button_r;
    prev_button_nxt = prev_button_r;
    valid_nxt       = valid_r;
    done_nxt        = 1'b0;
    rx_we           = 1'b0;
    rx_addr         = RX_W'(byte_index_r);

    case (phase_r)
      PH_IDLE: begin
        if (op) begin
          byte_index_nxt = '0;
          if (byte_gap_r != 8'd0) begin
            phase_nxt      = PH_LEAD;
            tick_timer_nxt = 8'd0;
          end else begin
            phase_nxt      = PH_LOW;
            bit_index_nxt  = 3'd0;
            shift_one_nxt  = 8'd0;
            shift_two_nxt  = 8'd0;
            tick_timer_nxt = 8'd0;
          end
        end
      end
      PH_LEAD: begin
        if (tick_inc >= {1'b0, byte_gap_r}) begin
          phase_nxt      = PH_LOW;
          bit_index_nxt  = 3'd0;
          shift_one_nxt  = 8'd0;
          shift_two_nxt  = 8'd0;
          tick_timer_nxt = 8'd0;
        end else begin
          tick_timer_nxt = tick_inc[7:0];
        end
      end
      PH_LOW: begin
        if (tick_inc >= low_len) begin
          shift_one_nxt  = shift_one_r | (8'(data_one) << bit_index_r);
          shift_two_nxt  = shift_two_r | (8'(data_two) << bit_index_r);
          rx_we          = (bit_index_r == 3'd7) && (5'(byte_index_r) < 5'(STORED_BYTES));
          phase_nxt      = PH_HIGH;
          tick_timer_nxt = 8'd0;
        end else begin
          tick_timer_nxt = tick_inc[7:0];
        end
      end
      PH_HIGH: begin
        if (tick_inc > {1'b0, clock_high_r}) begin
          if (bit_index_r != 3'd7) begin
            bit_index_nxt  = bit_index_r + 3'd1;
            phase_nxt      = PH_LOW;
            tick_timer_nxt = 8'd0;
          end else if (byte_gap_r != 8'd0) begin
            phase_nxt      = PH_GAP;
            tick_timer_nxt = 8'd0;
          end else begin
            byte_end = 1'b1;
          end
        end else begin
          tick_timer_nxt = tick_inc[7:0];
        end
      end
      PH_GAP: begin
        if (tick_inc >= {1'b0, byte_gap_r}) begin
          byte_end = 1'b1;
        end else begin
          tick_timer_nxt = tick_inc[7:0];
        end
      end
      default: begin
        phase_nxt      = PH_IDLE;
        tick_timer_nxt = 8'd0;
      end
    endcase

    // End of a byte: either the next byte starts or the frame is closed.
    if (byte_end) begin
      if (bi_inc >= (BI_W + 1)'(FRAME_BYTES)) begin
        prev_button_nxt = button_r;
        button_nxt      = {rx_two_r[4], rx_two_r[3], rx_one_r[4], rx_one_r[3]};
        valid_nxt       = {header_ok(rx_two_r[0], rx_two_r[1], rx_two_r[2]),
                           header_ok(rx_one_r[0], rx_one_r[1], rx_one_r[2])};
        phase_nxt       = PH_IDLE;
        tick_timer_nxt  = 8'd0;
        byte_index_nxt  = '0;
        bit_index_nxt   = 3'd0;
        done_nxt        = 1'b1;
      end else begin
        byte_index_nxt = bi_inc[BI_W-1:0];
        phase_nxt      = PH_LOW;
        bit_index_nxt  = 3'd0;
        shift_one_nxt  = 8'd0;
        shift_two_nxt  = 8'd0;
        tick_timer_nxt = 8'd0;
      end
    end
  end

  // Pin levels and masks as they stand after this tick.
  always_comb begin
    logic [31:0] changed;
    logic [7:0]  cmd_byte;
    changed  = prev_button_nxt ^ button_nxt;
    cmd_byte = command_byte(5'(byte_index_nxt));

    res.clock_pin     = (phase_nxt != PH_LOW);
    res.command_pin   = ((phase_nxt == PH_LOW) || (phase_nxt == PH_HIGH)) ?
                        cmd_byte[bit_index_nxt] : 1'b1;
    res.attention_pin = (phase_nxt == PH_IDLE);
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = done_nxt;
    res.pad_one_valid = valid_nxt[0];
    res.pad_two_valid = valid_nxt[1];
    res.held_mask     = ~button_nxt;
    res.pressed_mask  = changed & ~button_nxt;
    res.released_mask = changed & ~prev_button_nxt;
    res.any_change    = (changed != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      byte_index_r  <= '0;
      bit_index_r   <= 3'd0;
      tick_timer_r  <= 8'd0;
      shift_one_r   <= 8'd0;
      shift_two_r   <= 8'd0;
      button_r      <= '1;
      prev_button_r <= '1;
      valid_r       <= 2'b00;
    end else if (step) begin
      phase_r       <= phase_nxt;
      byte_index_r  <= byte_index_nxt;
      bit_index_r   <= bit_index_nxt;
      tick_timer_r  <= tick_timer_nxt;
      shift_one_r   <= shift_one_nxt;
      shift_two_r   <= shift_two_nxt;
      button_r      <= button_nxt;
      prev_button_r <= prev_button_nxt;
      valid_r       <= valid_nxt;
    end
  end

  // Received bytes carry no reset; every frame writes them before they are read.
  always_ff @(posedge clk) begin
    if (step && rx_we) begin
      rx_one_r[rx_addr] <= shift_one_nxt;
      rx_two_r[rx_addr] <= shift_two_nxt;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_timer_r == 8'd0) && (bit_index_r == 3'd0))
    else $error("idle phase with running counters");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.done_res) |=> (phase_r == PH_IDLE))
    else $error("frame completed but sequencer not idle");

  a_clock_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (!res.clock_pin) |-> (res.busy_res && !res.attention_pin))
    else $error("serial clock low outside a frame");

endmodule

`default_nettype wire

// ===== rtl/dgsp_outq.sv =====
// Two-entry result queue that decouples the tick input from the result output.
// Uses dgsp_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module dgsp_outq
  import dgsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  result_t   push_data,
  output logic      space,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_data
);

  result_t    slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign space     = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) |-> !push)
    else $error("request pushed into a full result queue");

endmodule

`default_nettype wire
